>>> rtl/framed_manchester_emitter_unit_macros.svh
// Assertion macros shared by the framed Manchester emitter RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef FRAMED_MANCHESTER_EMITTER_UNIT_MACROS_SVH
`define FRAMED_MANCHESTER_EMITTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge out of reset.
`define FME_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check a consequence in the same cycle as its cause.
`define FME_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Check a consequence in the cycle after its cause.
`define FME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FME_ASSERT_ALWAYS(lbl, expr, msg)
`define FME_ASSERT_IMPL(lbl, ante, cons, msg)
`define FME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/fme_pkg.sv
// Shared types, codes and the Manchester word encoder of the framed emitter.
// No dependencies.
package fme_pkg;

    typedef logic [1:0] op_t;
    localparam op_t OP_TICK = 2'd0;
    localparam op_t OP_BYTE = 2'd1;
    localparam op_t OP_LAST = 2'd2;

    typedef logic [2:0] status_t;
    localparam status_t ST_TICK      = 3'd0;
    localparam status_t ST_STORED    = 3'd1;
    localparam status_t ST_STARTED   = 3'd2;
    localparam status_t ST_BUSY      = 3'd3;
    localparam status_t ST_TOO_LONG  = 3'd4;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SYNC  = 2'd0;
    localparam cfg_idx_t CFG_STX   = 2'd1;
    localparam cfg_idx_t CFG_ETX   = 2'd2;

    localparam logic [7:0] SYNC_RESET    = 8'd213;
    localparam logic [7:0] STX_RESET     = 8'd2;
    localparam logic [7:0] ETX_RESET     = 8'd3;
    localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;

    localparam logic [4:0] WORD_HALF_BITS = 5'd20;
    localparam logic [6:0] PREAMBLE_LEN   = 7'd3;
    localparam logic [6:0] SYNC_POS       = 7'd3;
    localparam logic [6:0] STX_POS        = 7'd4;
    localparam logic [6:0] PAYLOAD_POS    = 7'd5;
    localparam logic [6:0] FRAME_OVERHEAD = 7'd6;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [7:0] start_text_byte;
        logic [7:0] end_text_byte;
    } cfg_t;

    // Start 1,0; data LSB first (1 -> 0,1 and 0 -> 1,0); stop 0,1.
    function automatic logic [31:0] encode_word(input logic [7:0] byte_in);
        logic [31:0] word;
        word = 32'h0000_0001;
        for (int i = 0; i < 8; i++)
        begin
            word[2 + 2 * i]     = ~byte_in[i];
            word[2 + 2 * i + 1] = byte_in[i];
        end
        word[19] = 1'b1;
        return word;
    endfunction

endpackage

>>> rtl/fme_front.sv
// Front end of the framed emitter: input acceptance, classification, 2-entry queue.
// Depends on fme_pkg and the assertion macro header.
`include "framed_manchester_emitter_unit_macros.svh"
module fme_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    input  logic            s_tuser,
    input  logic            s_tlast,
    output logic            q_valid,
    input  logic            q_ready,
    output fme_pkg::item_t  q_item
);
    import fme_pkg::*;

    localparam logic [1:0] QUEUE_FULL = 2'd2;

    item_t       entry_reg [0:1];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;
    item_t       classified;

    assign s_tready = (cnt_reg != QUEUE_FULL);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // Decode kind and last flag into one operation code.
    always_comb
    begin
        classified.data = s_tdata;
        if (!s_tuser)
            classified.op = OP_TICK;
        else if (s_tlast)
            classified.op = OP_LAST;
        else
            classified.op = OP_BYTE;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= classified;
    end

    `FME_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= QUEUE_FULL, "queue count above depth")
    `FME_ASSERT_NEXT(a_push_grows, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1, "push lost")
    `FME_ASSERT_NEXT(a_pop_shrinks, pop && !push, cnt_reg == $past(cnt_reg) - 2'd1, "pop lost")
    `FME_ASSERT_IMPL(a_ptr_match, cnt_reg == 2'd0, wr_ptr_reg == rd_ptr_reg, "empty queue ptr skew")

endmodule

>>> rtl/fme_back.sv
// Back end of the framed emitter: payload store, frame sequencer, shift register,
// result register. Depends on fme_pkg and the assertion macro header.
`include "framed_manchester_emitter_unit_macros.svh"
module fme_back #(
    parameter int unsigned PAYLOAD_MAX = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  fme_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  fme_pkg::item_t  item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_line,
    output logic [2:0]      out_status,
    output logic            out_busy
);
    import fme_pkg::*;

    localparam int unsigned AW   = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam logic [6:0]  PMAX = 7'(PAYLOAD_MAX);

    logic [7:0]  payload_store_reg [0:PAYLOAD_MAX-1];
    logic [7:0]  rd_data_reg;

    logic [6:0]  load_count_reg, load_count_next;
    logic        load_ovf_reg, load_ovf_next;
    logic        active_reg, active_next;
    logic [6:0]  pos_reg, pos_next;
    logic [6:0]  len_reg, len_next;
    logic [31:0] shift_reg, shift_next;
    logic [4:0]  hb_reg, hb_next;

    logic        out_valid_reg, out_valid_next;
    logic        line_reg, line_next;
    status_t     status_reg, status_next;
    logic        busy_reg;

    logic        advance;
    logic        mem_we;
    logic [6:0]  pay_off;
    logic [6:0]  pay_cnt;
    logic [4:0]  hb_dec;
    logic [7:0]  frame_byte;

    assign in_ready   = !out_valid_reg || out_ready;
    assign advance    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_line   = line_reg;
    assign out_status = status_reg;
    assign out_busy   = busy_reg;

    assign pay_off = pos_reg - PAYLOAD_POS;
    assign pay_cnt = len_reg - FRAME_OVERHEAD;
    assign hb_dec  = hb_reg - 5'd1;

    // Pick the byte at the current frame position.
    always_comb
    begin
        if (pos_reg < PREAMBLE_LEN)
            frame_byte = PREAMBLE_BYTE;
        else if (pos_reg == SYNC_POS)
            frame_byte = cfg.sync_byte;
        else if (pos_reg == STX_POS)
            frame_byte = cfg.start_text_byte;
        else if (pay_off < pay_cnt)
            frame_byte = rd_data_reg;
        else
            frame_byte = cfg.end_text_byte;
    end

    always_comb
    begin
        load_count_next = load_count_reg;
        load_ovf_next   = load_ovf_reg;
        active_next     = active_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        shift_next      = shift_reg;
        hb_next         = hb_reg;
        line_next       = 1'b0;
        status_next     = ST_TICK;
        mem_we          = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;

        if (advance)
        begin
            out_valid_next = 1'b1;
            case (item.op)
                OP_TICK:
                begin
                    line_next  = shift_reg[0];
                    shift_next = {1'b0, shift_reg[31:1]};
                    hb_next    = hb_dec;
                    if (hb_dec == 5'd0)
                    begin
                        hb_next = WORD_HALF_BITS;
                        if (active_reg)
                        begin
                            if (pos_reg < len_reg)
                            begin
                                shift_next = encode_word(frame_byte);
                                pos_next   = pos_reg + 7'd1;
                            end
                            else
                            begin
                                active_next = 1'b0;
                                pos_next    = 7'd0;
                                len_next    = 7'd0;
                            end
                        end
                    end
                end
                OP_BYTE, OP_LAST:
                begin
                    if (active_reg)
                        status_next = ST_BUSY;
                    else
                    begin
                        if (load_count_reg < PMAX)
                        begin
                            mem_we          = 1'b1;
                            load_count_next = load_count_reg + 7'd1;
                        end
                        else
                            load_ovf_next = 1'b1;

                        if (item.op == OP_LAST)
                        begin
                            if (load_ovf_next)
                                status_next = ST_TOO_LONG;
                            else
                            begin
                                len_next    = load_count_next + FRAME_OVERHEAD;
                                pos_next    = 7'd0;
                                active_next = 1'b1;
                                status_next = ST_STARTED;
                            end
                            load_count_next = 7'd0;
                            load_ovf_next   = 1'b0;
                        end
                        else
                            status_next = load_ovf_next ? ST_TOO_LONG : ST_STORED;
                    end
                end
                default:
                begin
                    status_next = ST_TICK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= 7'd0;
            load_ovf_reg   <= 1'b0;
            active_reg     <= 1'b0;
            pos_reg        <= 7'd0;
            len_reg        <= 7'd0;
            shift_reg      <= 32'hFFFF_FFFF;
            hb_reg         <= WORD_HALF_BITS;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            load_ovf_reg   <= load_ovf_next;
            active_reg     <= active_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            shift_reg      <= shift_next;
            hb_reg         <= hb_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload: load on advance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            line_reg   <= line_next;
            status_reg <= status_next;
            busy_reg   <= active_next;
        end
    end

    // Payload store: write at the fill count, read ahead at the frame position.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            payload_store_reg[load_count_reg[AW-1:0]] <= item.data;
        rd_data_reg <= payload_store_reg[pay_off[AW-1:0]];
    end

    `FME_ASSERT_ALWAYS(a_hb_range, (hb_reg != 5'd0) && (hb_reg <= WORD_HALF_BITS), "hb range")
    `FME_ASSERT_IMPL(a_len_valid, active_reg, len_reg > FRAME_OVERHEAD, "short frame active")
    `FME_ASSERT_IMPL(a_pos_bound, active_reg, pos_reg <= len_reg, "frame position past end")
    `FME_ASSERT_IMPL(a_idle_clear, !active_reg, (pos_reg == 7'd0) && (len_reg == 7'd0), "idle dirty")
    `FME_ASSERT_IMPL(a_ovf_full, load_ovf_reg, load_count_reg == PMAX, "overflow before full")

endmodule

>>> rtl/framed_manchester_emitter_unit.sv
// Top level of the framed Manchester emitter: configuration registers and port packing.
// Depends on fme_pkg, fme_front and fme_back.
//
//  Channel  Dir  Handshake          Contents
//  s_*      in   tvalid/tready      tdata: data_byte; tuser: kind; tlast: last_byte
//  m_*      out  tvalid/tready      tdata: line_level, busy_res; tuser: status
//  cfg_*    in   cfg_we only        cfg_index selects sync, start-of-text, end-of-text byte
//
// One transaction is accepted per cycle while the front queue has room; each input
// transaction yields exactly one result transaction, held first in the front queue and
// then in the result register. The back end updates all frame state for each item.
// Reset clears all control state; the payload store is not cleared and needs no sweep.
// A stalled output holds its result; the two-entry front queue takes input until full.
module framed_manchester_emitter_unit #(
    parameter int unsigned PAYLOAD_MAX = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] kind
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] line_level, [1] busy_res, [7:2] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import fme_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   q_valid;
    logic   q_ready;
    item_t  q_item;
    logic   res_line;
    logic   res_busy;

    // Write the selected register; drop writes to unknown indexes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC: cfg_next.sync_byte       = cfg_data;
                CFG_STX:  cfg_next.start_text_byte = cfg_data;
                CFG_ETX:  cfg_next.end_text_byte   = cfg_data;
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_byte       <= SYNC_RESET;
            cfg_reg.start_text_byte <= STX_RESET;
            cfg_reg.end_text_byte   <= ETX_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    // Accept and classify input items, buffer them for the back end.
    fme_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // Advance the frame sequencer and line shift register, register the result.
    fme_back #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .item       (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_line   (res_line),
        .out_status (m_tuser),
        .out_busy   (res_busy)
    );

    assign m_tdata = {6'b00_0000, res_busy, res_line};

endmodule
